### design/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types and widths for the dielectric Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam int CosWidth    = 16;
  localparam int IndexWidth  = 16;
  localparam int ReflWidth   = 17;

  // Transmitted squared cosine division: 62-bit numerator over nt^2.
  localparam int CosDivDw    = 32;
  localparam int CosDivQw    = 31;

  // Square root of the Q0.32 squared cosine, one root bit per cell.
  localparam int SqrtRootW   = 17;

  // Amplitude ratio division: 51-bit numerator over a 34-bit sum.
  localparam int RatioDivDw  = 34;
  localparam int RatioDivQw  = 17;

  // Side data that rides along the cosine and root chains: mag, ni, nt, tir.
  localparam int SideWidth   = CosWidth + 2 * IndexWidth + 1;
  // Side data of the ratio chains: tir and the two zero-sum flags.
  localparam int RatioSideW  = 3;

  localparam int LatencyCycles = 73;

  typedef struct packed {
    logic signed [CosWidth-1:0]   cos_incident;
    logic        [IndexWidth-1:0] index_incident;
    logic        [IndexWidth-1:0] index_transmit;
  } request_t;

  typedef struct packed {
    logic [ReflWidth-1:0] reflectance;
    logic                 total_internal;
  } result_t;

endpackage

### design/dfr_div_cell.sv
// ----------------------------------------------------------------------------
// dfr_div_cell
// One restoring division step: produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dfr_div_cell
  import dfr_pkg::*;
#(
  parameter int DW = CosDivDw,
  parameter int QW = CosDivQw,
  parameter int SW = SideWidth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid_in,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] lq_in,
  input  logic [DW-1:0] div_in,
  input  logic [SW-1:0] side_in,
  output logic          valid_out,
  output logic [DW-1:0] rem_out,
  output logic [QW-1:0] lq_out,
  output logic [DW-1:0] div_out,
  output logic [SW-1:0] side_out
);

  logic [DW:0]   trial;
  logic          ge;
  logic [DW-1:0] rem_next;

  // The dividend bits shift out of the top of lq while quotient bits
  // shift into its bottom, so after QW cells lq holds the quotient.
  always_comb begin
    trial    = {rem_in, lq_in[QW-1]};
    ge       = (trial >= {1'b0, div_in});
    rem_next = ge ? DW'(trial - {1'b0, div_in}) : DW'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    rem_out  <= rem_next;
    lq_out   <= {lq_in[QW-2:0], ge};
    div_out  <= div_in;
    side_out <= side_in;
  end

endmodule

### design/dfr_sqrt_cell.sv
// ----------------------------------------------------------------------------
// dfr_sqrt_cell
// One digit-by-digit square root step: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module dfr_sqrt_cell
  import dfr_pkg::*;
#(
  parameter int RW = SqrtRootW,
  parameter int SW = SideWidth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid_in,
  input  logic [RW+1:0]   rem_in,
  input  logic [RW-1:0]   root_in,
  input  logic [2*RW-1:0] bits_in,
  input  logic [SW-1:0]   side_in,
  output logic            valid_out,
  output logic [RW+1:0]   rem_out,
  output logic [RW-1:0]   root_out,
  output logic [2*RW-1:0] bits_out,
  output logic [SW-1:0]   side_out
);

  logic [RW+3:0] widened;
  logic [RW+3:0] trial;
  logic          ge;
  logic [RW+1:0] rem_next;

  always_comb begin
    widened  = {rem_in, bits_in[2*RW-1:2*RW-2]};
    trial    = {2'b00, root_in, 2'b01};
    ge       = (widened >= trial);
    rem_next = ge ? (RW+2)'(widened - trial) : (RW+2)'(widened);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    rem_out  <= rem_next;
    root_out <= {root_in[RW-2:0], ge};
    bits_out <= {bits_in[2*RW-3:0], 2'b00};
    side_out <= side_in;
  end

endmodule

### design/dielectric_fresnel_reflectance.sv
// ----------------------------------------------------------------------------
// dielectric_fresnel_reflectance
// Unpolarized Fresnel reflectance of a dielectric interface in fixed point.
// ----------------------------------------------------------------------------
// Stages: four front stages, the 31-cell cosine divider, the 17-cell root chain,
// the 17-cell ratio dividers and four product and output stages.
// Throughput: one beat per cycle; busy is always low and the receiver cannot
// stall, so each result shows on result for exactly one cycle with done high.
// Reset: synchronous rst clears every valid bit in the pipeline; items in
// flight are dropped and no done strobe follows them.
module dielectric_fresnel_reflectance
  import dfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  localparam int SRadW = 2 * SqrtRootW;

  assign busy = 1'b0;

  // Front stages: fold the cosine, form squares, then the TIR test.
  logic                  s0_valid;
  logic [CosWidth-1:0]   s0_mag;
  logic [IndexWidth-1:0] s0_ni, s0_nt;

  logic                  s1_valid;
  logic [CosWidth-1:0]   s1_mag;
  logic [IndexWidth-1:0] s1_ni, s1_nt;
  logic [30:0]           s1_sin2;
  logic [31:0]           s1_ni2, s1_nt2;

  logic                  s2_valid;
  logic [CosWidth-1:0]   s2_mag;
  logic [IndexWidth-1:0] s2_ni, s2_nt;
  logic [62:0]           s2_lhs;
  logic [31:0]           s2_nt2;

  logic                  s3_valid;
  logic [SideWidth-1:0]  s3_side;
  logic [61:0]           s3_num;
  logic [31:0]           s3_nt2;

  logic                  entering;
  logic [CosWidth-1:0]   fold_mag;
  logic [31:0]           mag_sq;
  logic [61:0]           rhs;

  always_comb begin
    entering = !request.cos_incident[CosWidth-1] && (request.cos_incident != '0);
    fold_mag = request.cos_incident[CosWidth-1] ?
               CosWidth'(~request.cos_incident + 1'b1) : request.cos_incident;
    mag_sq   = s0_mag * s0_mag;
    rhs      = {s2_nt2, 30'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    s0_mag  <= fold_mag;
    s0_ni   <= entering ? request.index_incident : request.index_transmit;
    s0_nt   <= entering ? request.index_transmit : request.index_incident;

    s1_mag  <= s0_mag;
    s1_ni   <= s0_ni;
    s1_nt   <= s0_nt;
    s1_sin2 <= 31'((32'd1 << 30) - mag_sq);
    s1_ni2  <= s0_ni * s0_ni;
    s1_nt2  <= s0_nt * s0_nt;

    s2_mag  <= s1_mag;
    s2_ni   <= s1_ni;
    s2_nt   <= s1_nt;
    s2_lhs  <= s1_ni2 * s1_sin2;
    s2_nt2  <= s1_nt2;

    s3_side <= {s2_mag, s2_ni, s2_nt, (s2_lhs >= {1'b0, rhs})};
    s3_num  <= rhs - s2_lhs[61:0];
    s3_nt2  <= s2_nt2;
  end

  // Cosine divider chain: floor((rhs - lhs) / nt^2).
  logic                 d1_valid [0:CosDivQw];
  logic [CosDivDw-1:0]  d1_rem   [0:CosDivQw];
  logic [CosDivQw-1:0]  d1_lq    [0:CosDivQw];
  logic [CosDivDw-1:0]  d1_div   [0:CosDivQw];
  logic [SideWidth-1:0] d1_side  [0:CosDivQw];

  assign d1_valid[0] = s3_valid;
  assign d1_rem[0]   = {1'b0, s3_num[61:31]};
  assign d1_lq[0]    = s3_num[30:0];
  assign d1_div[0]   = s3_nt2;
  assign d1_side[0]  = s3_side;

  for (genvar i = 0; i < CosDivQw; i++) begin : g_cdiv
    dfr_div_cell #(.DW(CosDivDw), .QW(CosDivQw), .SW(SideWidth)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (d1_valid[i]),
      .rem_in    (d1_rem[i]),
      .lq_in     (d1_lq[i]),
      .div_in    (d1_div[i]),
      .side_in   (d1_side[i]),
      .valid_out (d1_valid[i+1]),
      .rem_out   (d1_rem[i+1]),
      .lq_out    (d1_lq[i+1]),
      .div_out   (d1_div[i+1]),
      .side_out  (d1_side[i+1])
    );
  end

  // Root chain over the squared cosine scaled to Q0.32.
  logic                 sq_valid [0:SqrtRootW];
  logic [SqrtRootW+1:0] sq_rem   [0:SqrtRootW];
  logic [SqrtRootW-1:0] sq_root  [0:SqrtRootW];
  logic [SRadW-1:0]     sq_bits  [0:SqrtRootW];
  logic [SideWidth-1:0] sq_side  [0:SqrtRootW];

  assign sq_valid[0] = d1_valid[CosDivQw];
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_bits[0]  = SRadW'({d1_lq[CosDivQw], 2'b00});
  assign sq_side[0]  = d1_side[CosDivQw];

  for (genvar i = 0; i < SqrtRootW; i++) begin : g_sqrt
    dfr_sqrt_cell #(.RW(SqrtRootW), .SW(SideWidth)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (sq_valid[i]),
      .rem_in    (sq_rem[i]),
      .root_in   (sq_root[i]),
      .bits_in   (sq_bits[i]),
      .side_in   (sq_side[i]),
      .valid_out (sq_valid[i+1]),
      .rem_out   (sq_rem[i+1]),
      .root_out  (sq_root[i+1]),
      .bits_out  (sq_bits[i+1]),
      .side_out  (sq_side[i+1])
    );
  end

  // Products for both polarizations, then difference and rounded numerator.
  logic [CosWidth-1:0]   r_mag;
  logic [IndexWidth-1:0] r_ni, r_nt;
  logic                  r_tir;
  logic [16:0]           ci;
  logic [16:0]           ct;

  assign {r_mag, r_ni, r_nt, r_tir} = sq_side[SqrtRootW];
  assign ci = {r_mag, 1'b0};
  assign ct = sq_root[SqrtRootW];

  logic        p_valid, p_tir;
  logic [32:0] p_par, q_par, p_perp, q_perp;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= sq_valid[SqrtRootW];
    end
    p_tir  <= r_tir;
    p_par  <= r_nt * ci;
    q_par  <= r_ni * ct;
    p_perp <= r_ni * ci;
    q_perp <= r_nt * ct;
  end

  logic [32:0] diff_par, diff_perp;
  logic [33:0] sum_par, sum_perp;

  always_comb begin
    diff_par  = (p_par > q_par) ? (p_par - q_par) : (q_par - p_par);
    diff_perp = (p_perp > q_perp) ? (p_perp - q_perp) : (q_perp - p_perp);
    sum_par   = {1'b0, p_par} + {1'b0, q_par};
    sum_perp  = {1'b0, p_perp} + {1'b0, q_perp};
  end

  localparam int RatioNw = RatioDivDw + RatioDivQw;

  logic                  q_valid;
  logic [RatioSideW-1:0] q_side;
  logic [RatioNw-1:0]    q_num_par, q_num_perp;
  logic [RatioDivDw-1:0] q_sum_par, q_sum_perp;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= p_valid;
    end
    q_side     <= {p_tir, (sum_par == '0), (sum_perp == '0)};
    q_num_par  <= RatioNw'({diff_par, 16'b0}) + RatioNw'(sum_par[33:1]);
    q_num_perp <= RatioNw'({diff_perp, 16'b0}) + RatioNw'(sum_perp[33:1]);
    q_sum_par  <= sum_par;
    q_sum_perp <= sum_perp;
  end

  // Two ratio divider lanes side by side; lane zero carries the side data used.
  logic                  rd_valid [0:1][0:RatioDivQw];
  logic [RatioDivDw-1:0] rd_rem   [0:1][0:RatioDivQw];
  logic [RatioDivQw-1:0] rd_lq    [0:1][0:RatioDivQw];
  logic [RatioDivDw-1:0] rd_div   [0:1][0:RatioDivQw];
  logic [RatioSideW-1:0] rd_side  [0:1][0:RatioDivQw];

  assign rd_valid[0][0] = q_valid;
  assign rd_rem[0][0]   = q_num_par[RatioNw-1:RatioDivQw];
  assign rd_lq[0][0]    = q_num_par[RatioDivQw-1:0];
  assign rd_div[0][0]   = q_sum_par;
  assign rd_side[0][0]  = q_side;
  assign rd_valid[1][0] = q_valid;
  assign rd_rem[1][0]   = q_num_perp[RatioNw-1:RatioDivQw];
  assign rd_lq[1][0]    = q_num_perp[RatioDivQw-1:0];
  assign rd_div[1][0]   = q_sum_perp;
  assign rd_side[1][0]  = q_side;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar i = 0; i < RatioDivQw; i++) begin : g_rdiv
      dfr_div_cell #(.DW(RatioDivDw), .QW(RatioDivQw), .SW(RatioSideW)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .valid_in  (rd_valid[l][i]),
        .rem_in    (rd_rem[l][i]),
        .lq_in     (rd_lq[l][i]),
        .div_in    (rd_div[l][i]),
        .side_in   (rd_side[l][i]),
        .valid_out (rd_valid[l][i+1]),
        .rem_out   (rd_rem[l][i+1]),
        .lq_out    (rd_lq[l][i+1]),
        .div_out   (rd_div[l][i+1]),
        .side_out  (rd_side[l][i+1])
      );
    end
  end

  // A zero sum means a ratio magnitude of one.
  logic        o_tir, o_zpar, o_zperp;
  logic [16:0] rpar, rperp;

  always_comb begin
    {o_tir, o_zpar, o_zperp} = rd_side[0][RatioDivQw];
    rpar  = o_zpar  ? 17'h10000 : rd_lq[0][RatioDivQw];
    rperp = o_zperp ? 17'h10000 : rd_lq[1][RatioDivQw];
  end

  logic        sq2_valid, sq2_tir;
  logic [33:0] sq2_par, sq2_perp;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq2_valid <= 1'b0;
    end else begin
      sq2_valid <= rd_valid[0][RatioDivQw] && rd_valid[1][RatioDivQw];
    end
    sq2_tir  <= o_tir;
    sq2_par  <= rpar * rpar;
    sq2_perp <= rperp * rperp;
  end

  logic [34:0] total;
  logic [17:0] mean;
  result_t     result_next;

  always_comb begin
    total = {1'b0, sq2_par} + {1'b0, sq2_perp} + 35'h10000;
    mean  = total[34:17];
    result_next.total_internal = sq2_tir;
    if (sq2_tir || (mean > 18'h10000)) begin
      result_next.reflectance = 17'h10000;
    end else begin
      result_next.reflectance = mean[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sq2_valid;
    end
    result <= result_next;
  end

endmodule

### design/dfr_checker.sv
// ----------------------------------------------------------------------------
// dfr_checker
// Port-level checks of the Fresnel pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module dfr_checker
  import dfr_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input request_t request,
  input logic     done,
  input result_t  result
);

  // Every accepted beat is answered by a done strobe.
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##73 done)
    else $error("accepted beat produced no result at the expected cycle");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 73))
    else $error("result strobe without a matching accepted beat");

  a_tir_full : assert property (@(posedge clk) disable iff (rst)
    (done && result.total_internal) |-> (result.reflectance == 17'h10000))
    else $error("total internal reflection without full reflectance");

  a_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (result.reflectance <= 17'h10000))
    else $error("reflectance above one");

endmodule

bind dielectric_fresnel_reflectance dfr_checker u_dfr_checker (.*);

### test/testbench.sv
// ----------------------------------------------------------------------------
// Dielectric Fresnel reflectance testbench
// Drives cosine and index beats with random gaps, predicts each reflectance
// and total-internal flag in the bench, and checks results in order.
// ----------------------------------------------------------------------------
module testbench
  import dfr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  class reflectance_board;
    result_t pending[$];
    int      errors;
    int      checked;
    int      tir_seen;

    function new();
      errors   = 0;
      checked  = 0;
      tir_seen = 0;
    endfunction

    static function logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= r + bitv) begin
          v = v - (r + bitv);
          r = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
        bitv = bitv >> 2;
      end
      return r;
    endfunction

    static function logic [63:0] amp_ratio(logic [63:0] p, logic [63:0] q);
      logic [63:0] diff;
      logic [63:0] sum;
      diff = (p > q) ? p - q : q - p;
      sum = p + q;
      if (sum == 0) return 64'd65536;
      return ((diff << 16) + (sum >> 1)) / sum;
    endfunction

    static function result_t fresnel(request_t rq);
      logic [63:0] craw, ni, nt, mag, swp, sin2, lhs, rhs, cos2t, ct, ci;
      logic [63:0] rpar, rperp, refl;
      result_t     res;
      craw = 64'(rq.cos_incident) & 64'hFFFF;
      ni = 64'(rq.index_incident);
      nt = 64'(rq.index_transmit);
      // A zero or negative cosine means the ray leaves: swap the indices.
      if (craw != 0 && craw < 64'h8000) begin
        mag = craw;
      end else begin
        mag = (craw == 0) ? 64'd0 : ((64'h10000 - craw) & 64'h1FFFF);
        swp = ni;
        ni = nt;
        nt = swp;
      end
      sin2 = (64'd1 << 30) - mag * mag;
      lhs = ni * ni * sin2;
      rhs = (nt * nt) << 30;
      if (lhs >= rhs) begin
        res.reflectance = 17'd65536;
        res.total_internal = 1'b1;
        return res;
      end
      cos2t = (rhs - lhs) / (nt * nt);
      ct = root_floor(cos2t << 2);
      ci = mag << 1;
      rpar = amp_ratio(nt * ci, ni * ct);
      rperp = amp_ratio(ni * ci, nt * ct);
      refl = (rpar * rpar + rperp * rperp + (64'd1 << 16)) >> 17;
      if (refl > 64'd65536) refl = 64'd65536;
      res.reflectance = refl[16:0];
      res.total_internal = 1'b0;
      return res;
    endfunction

    function void note_request(request_t rq);
      pending.push_back(fresnel(rq));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: reflectance %0d total_internal %0d",
               got.reflectance, got.total_internal);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.total_internal) tir_seen++;
      if (got.reflectance !== want.reflectance) begin
        $error("reflectance: expected %0d, got %0d", want.reflectance, got.reflectance);
        errors++;
      end
      if (got.total_internal !== want.total_internal) begin
        $error("total_internal: expected %0d, got %0d",
               want.total_internal, got.total_internal);
        errors++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  logic     done;
  request_t request = '0;
  result_t  result;

  reflectance_board board = new();
  int unsigned cycles = 0;
  int          sent = 0;

  dielectric_fresnel_reflectance u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && start && !busy) board.note_request(request);
    if (!rst && done) board.check_result(result);
    if (cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Presents one beat and holds it until accepted; idles for the gap after.
  task automatic send_beat(request_t rq, int gap);
    start <= 1'b1;
    request <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic request_t random_request();
    request_t rq;
    int       kind;
    kind = $urandom_range(0, 9);
    rq.cos_incident = 16'($urandom());
    rq.index_incident = 16'($urandom_range(256, 65535));
    rq.index_transmit = 16'($urandom_range(256, 65535));
    // Mostly physical indices near 1..2.5 so both branches stay busy.
    if (kind < 6) begin
      rq.index_incident = 16'($urandom_range(4096, 10240));
      rq.index_transmit = 16'($urandom_range(4096, 10240));
    end else if (kind == 6) begin
      rq.index_incident = 16'($urandom_range(0, 65535));
      rq.index_transmit = 16'($urandom_range(0, 65535));
    end else if (kind == 7) begin
      rq.index_transmit = rq.index_incident;
    end
    return rq;
  endfunction

  task automatic wait_drained();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  request_t directed[$];

  initial begin
    request_t rq;
    int       k;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes of the cosine, equal and unequal indices, zero indices.
    directed.push_back('{16'sd32767, 16'd4096, 16'd6144});
    directed.push_back('{16'sh8000, 16'd4096, 16'd6144});
    directed.push_back('{16'sd0, 16'd4096, 16'd6144});
    directed.push_back('{16'sd1, 16'd6144, 16'd4096});
    directed.push_back('{-16'sd1, 16'd4096, 16'd6144});
    directed.push_back('{16'sd32767, 16'd65535, 16'd256});
    directed.push_back('{16'sd32767, 16'd256, 16'd65535});
    directed.push_back('{16'sd16384, 16'd6144, 16'd4096});
    directed.push_back('{16'sd100, 16'd6144, 16'd4096});
    directed.push_back('{16'sd20000, 16'd0, 16'd4096});
    directed.push_back('{16'sd20000, 16'd4096, 16'd0});
    directed.push_back('{16'sd0, 16'd0, 16'd0});
    directed.push_back('{16'sd20000, 16'd5000, 16'd5000});
    directed.push_back('{-16'sd20000, 16'd5000, 16'd5000});
    directed.push_back('{16'sd32767, 16'd65535, 16'd65535});
    directed.push_back('{16'sh8000, 16'd65535, 16'd256});
    directed.push_back('{16'sh5555, 16'h5555, 16'hAAAA});
    directed.push_back('{16'shAAAA, 16'hAAAA, 16'h5555});
    directed.push_back('{16'sd0, 16'd4096, 16'd0});
    foreach (directed[i]) send_beat(directed[i], (i % 3 == 0) ? 1 : 0);

    for (k = 0; k < 1250; k++) begin
      rq = random_request();
      send_beat(rq, (k >= 300 && k < 400) ? 0 : gap_len());
      if (k == 600) begin
        start <= 1'b0;
        wait_drained();
      end
    end
    start <= 1'b0;
    wait_drained();
    repeat (LatencyCycles + 20) @(posedge clk);

    $display("Sent %0d beats, checked %0d results, %0d with total internal reflection.",
             sent, board.checked, board.tir_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
design/dfr_pkg.sv
design/dfr_div_cell.sv
design/dfr_sqrt_cell.sv
design/dielectric_fresnel_reflectance.sv
design/dfr_checker.sv
test/testbench.sv
